[rtl/core/vca_pkg.sv]
package vca_pkg;

  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned SOUND_W  = 8;
  localparam int unsigned MASK_W   = 8;
  localparam int unsigned CHAN_W   = 3;

  typedef enum logic [2:0] {
    OP_PLAY     = 3'd0,
    OP_STOP     = 3'd1,
    OP_PAUSE    = 3'd2,
    OP_RESUME   = 3'd3,
    OP_QUERY    = 3'd4,
    OP_STOP_ALL = 3'd5,
    OP_TICK     = 3'd6
  } vca_op_e;

  typedef enum logic [2:0] {
    CMD_NONE     = 3'd0,
    CMD_START    = 3'd1,
    CMD_HALT     = 3'd2,
    CMD_PAUSE    = 3'd3,
    CMD_RESUME   = 3'd4,
    CMD_HALT_ALL = 3'd5
  } vca_cmd_e;

  typedef enum logic [1:0] {
    RSN_FREE   = 2'd0,
    RSN_SAME   = 2'd1,
    RSN_LOOP   = 2'd2,
    RSN_OLDEST = 2'd3
  } vca_reason_e;

  typedef enum logic [1:0] {
    VS_STOPPED = 2'd0,
    VS_PLAYING = 2'd1,
    VS_PAUSED  = 2'd2
  } vca_vstate_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCAN  = 2'd1,
    ST_DRAIN = 2'd2,
    ST_APPLY = 2'd3
  } vca_state_e;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [SOUND_W-1:0]  sound;
    logic                looping;
    logic                paused;
  } vca_entry_t;

  typedef struct packed {
    logic start;
    logic sample;
    logic slot_valid;
  } vca_scan_ctl_t;

endpackage

[rtl/core/vca_scan.sv]
module vca_scan #(
  parameter int unsigned IDX_W = 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  vca_pkg::vca_scan_ctl_t        ctl_i,
  input  logic [IDX_W-1:0]              idx_i,
  input  vca_pkg::vca_entry_t           entry_i,
  input  logic [vca_pkg::SOUND_W-1:0]   sound_i,
  input  logic [vca_pkg::HANDLE_W-1:0]  target_i,
  output logic                          free_found_o,
  output logic [IDX_W-1:0]              free_idx_o,
  output logic                          same_found_o,
  output logic [IDX_W-1:0]              same_idx_o,
  output logic                          loop_found_o,
  output logic [IDX_W-1:0]              loop_idx_o,
  output logic                          any_found_o,
  output logic [IDX_W-1:0]              any_idx_o,
  output logic                          match_found_o,
  output logic [IDX_W-1:0]              match_idx_o,
  output vca_pkg::vca_entry_t           match_entry_o
);

  logic                         free_found_q, same_found_q, loop_found_q;
  logic                         any_found_q, match_found_q;
  logic [IDX_W-1:0]             free_idx_q, same_idx_q, loop_idx_q, any_idx_q, match_idx_q;
  logic [vca_pkg::HANDLE_W-1:0] same_h_q, loop_h_q, any_h_q;
  vca_pkg::vca_entry_t          match_entry_q;
  logic                         live;
  logic                         take_free, take_same, take_loop, take_any, take_match;

  assign live       = ctl_i.slot_valid;
  assign take_free  = !live && !free_found_q;
  assign take_same  = live && (entry_i.sound == sound_i)
                      && (!same_found_q || (entry_i.handle < same_h_q));
  assign take_loop  = live && entry_i.looping
                      && (!loop_found_q || (entry_i.handle < loop_h_q));
  assign take_any   = live && (!any_found_q || (entry_i.handle < any_h_q));
  assign take_match = live && (entry_i.handle == target_i) && !match_found_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_found_q  <= 1'b0;
      same_found_q  <= 1'b0;
      loop_found_q  <= 1'b0;
      any_found_q   <= 1'b0;
      match_found_q <= 1'b0;
    end else if (ctl_i.start) begin
      free_found_q  <= 1'b0;
      same_found_q  <= 1'b0;
      loop_found_q  <= 1'b0;
      any_found_q   <= 1'b0;
      match_found_q <= 1'b0;
    end else if (ctl_i.sample) begin
      if (take_free) free_found_q <= 1'b1;
      if (take_same) same_found_q <= 1'b1;
      if (take_loop) loop_found_q <= 1'b1;
      if (take_any) any_found_q <= 1'b1;
      if (take_match) match_found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.sample && !ctl_i.start) begin
      if (take_free) free_idx_q <= idx_i;
      if (take_same) begin
        same_idx_q <= idx_i;
        same_h_q   <= entry_i.handle;
      end
      if (take_loop) begin
        loop_idx_q <= idx_i;
        loop_h_q   <= entry_i.handle;
      end
      if (take_any) begin
        any_idx_q <= idx_i;
        any_h_q   <= entry_i.handle;
      end
      if (take_match) begin
        match_idx_q   <= idx_i;
        match_entry_q <= entry_i;
      end
    end
  end

  assign free_found_o  = free_found_q;
  assign free_idx_o    = free_idx_q;
  assign same_found_o  = same_found_q;
  assign same_idx_o    = same_idx_q;
  assign loop_found_o  = loop_found_q;
  assign loop_idx_o    = loop_idx_q;
  assign any_found_o   = any_found_q;
  assign any_idx_o     = any_idx_q;
  assign match_found_o = match_found_q;
  assign match_idx_o   = match_idx_q;
  assign match_entry_o = match_entry_q;

endmodule

[rtl/core/voice_channel_allocator.sv]
// Play, stop, pause, resume and query read every channel entry from the
// channel memory, one per cycle in the scan state, then pass the drain and
// apply states. Stop-all, tick and unused codes touch only the valid bits
// in apply. Requests are taken only when idle; apply waits on out_ready_i.
// Reset clears valid bits, handle counter and control at once; no memory
// sweep is needed.
module voice_channel_allocator #(
  parameter int unsigned CHANNELS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  operation_i,
  input  logic [7:0]  sound_id_i,
  input  logic        loop_request_i,
  input  logic [31:0] target_handle_i,
  input  logic [7:0]  playing_mask_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] new_handle_o,
  output logic [2:0]  channel_used_o,
  output logic [1:0]  steal_reason_o,
  output logic [2:0]  mixer_command_o,
  output logic        handle_unknown_o,
  output logic [1:0]  voice_state_o
);

  localparam int unsigned IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned TICK_N = (CHANNELS < 8) ? CHANNELS : 8;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);

  vca_pkg::vca_state_e                 state_q, state_d;
  logic [IDX_W-1:0]                    idx_q, idx_d;
  logic [IDX_W-1:0]                    rd_idx_q;
  logic                                rd_pend_q;
  logic [CHANNELS-1:0]                 valid_q, valid_d;
  logic [vca_pkg::HANDLE_W-1:0]        cnt_q, cnt_d, play_cnt;

  vca_pkg::vca_entry_t                 mem [CHANNELS];
  vca_pkg::vca_entry_t                 rdata_q;
  logic                                mem_we;
  logic [IDX_W-1:0]                    mem_waddr;
  vca_pkg::vca_entry_t                 mem_wdata;

  vca_pkg::vca_op_e                    op_in, op_q;
  logic [vca_pkg::SOUND_W-1:0]         sound_q;
  logic                                loop_q;
  logic [vca_pkg::HANDLE_W-1:0]        target_q;
  logic [vca_pkg::MASK_W-1:0]          mask_q;
  logic                                accept, scan_op, out_load;

  vca_pkg::vca_scan_ctl_t              scan_ctl;
  logic                                free_found, same_found, loop_found, any_found;
  logic                                match_found;
  logic [IDX_W-1:0]                    free_idx, same_idx, loop_idx, any_idx, match_idx;
  vca_pkg::vca_entry_t                 match_entry;

  logic [IDX_W-1:0]                    vic_idx, sel_idx;
  vca_pkg::vca_reason_e                vic_reason;
  logic [IDX_W+2:0]                    sel_ext;

  logic                                out_valid_q, out_valid_d;
  logic [vca_pkg::HANDLE_W-1:0]        new_handle_q, new_handle_d;
  logic [vca_pkg::CHAN_W-1:0]          chan_q, chan_d;
  vca_pkg::vca_reason_e                reason_q, reason_d;
  vca_pkg::vca_cmd_e                   cmd_q, cmd_d;
  logic                                unknown_q, unknown_d;
  vca_pkg::vca_vstate_e                vstate_q, vstate_d;

  assign op_in   = vca_pkg::vca_op_e'(operation_i);
  assign scan_op = (op_in == vca_pkg::OP_PLAY) || (op_in == vca_pkg::OP_STOP)
                   || (op_in == vca_pkg::OP_PAUSE) || (op_in == vca_pkg::OP_RESUME)
                   || (op_in == vca_pkg::OP_QUERY);
  assign in_ready_o = (state_q == vca_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == vca_pkg::ST_APPLY) && (!out_valid_q || out_ready_i);

  vca_scan #(
    .IDX_W(IDX_W)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (scan_ctl),
    .idx_i        (rd_idx_q),
    .entry_i      (rdata_q),
    .sound_i      (sound_q),
    .target_i     (target_q),
    .free_found_o (free_found),
    .free_idx_o   (free_idx),
    .same_found_o (same_found),
    .same_idx_o   (same_idx),
    .loop_found_o (loop_found),
    .loop_idx_o   (loop_idx),
    .any_found_o  (any_found),
    .any_idx_o    (any_idx),
    .match_found_o(match_found),
    .match_idx_o  (match_idx),
    .match_entry_o(match_entry)
  );

  always_comb begin
    if (free_found) begin
      vic_idx    = free_idx;
      vic_reason = vca_pkg::RSN_FREE;
    end else if (same_found) begin
      vic_idx    = same_idx;
      vic_reason = vca_pkg::RSN_SAME;
    end else if (loop_found) begin
      vic_idx    = loop_idx;
      vic_reason = vca_pkg::RSN_LOOP;
    end else if (any_found) begin
      vic_idx    = any_idx;
      vic_reason = vca_pkg::RSN_OLDEST;
    end else begin
      vic_idx    = '0;
      vic_reason = vca_pkg::RSN_FREE;
    end
  end

  assign sel_idx  = (op_q == vca_pkg::OP_PLAY) ? vic_idx : match_idx;
  assign sel_ext  = {3'b000, sel_idx};
  assign play_cnt = ((cnt_q + 32'd1) == '0) ? 32'd1 : (cnt_q + 32'd1);

  always_comb begin
    state_d             = state_q;
    idx_d               = idx_q;
    valid_d             = valid_q;
    cnt_d               = cnt_q;
    mem_we              = 1'b0;
    mem_waddr           = sel_idx;
    mem_wdata           = match_entry;
    scan_ctl.start      = accept;
    scan_ctl.sample     = rd_pend_q;
    scan_ctl.slot_valid = valid_q[rd_idx_q];
    out_valid_d         = out_valid_q && !out_ready_i;
    new_handle_d        = new_handle_q;
    chan_d              = chan_q;
    reason_d            = reason_q;
    cmd_d               = cmd_q;
    unknown_d           = unknown_q;
    vstate_d            = vstate_q;

    case (state_q)
      vca_pkg::ST_IDLE: begin
        if (accept) begin
          idx_d   = '0;
          state_d = scan_op ? vca_pkg::ST_SCAN : vca_pkg::ST_APPLY;
        end
      end
      vca_pkg::ST_SCAN: begin
        if (idx_q == LAST_IDX) begin
          state_d = vca_pkg::ST_DRAIN;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      vca_pkg::ST_DRAIN: begin
        state_d = vca_pkg::ST_APPLY;
      end
      vca_pkg::ST_APPLY: begin
        if (out_load) begin
          out_valid_d  = 1'b1;
          new_handle_d = '0;
          chan_d       = '0;
          reason_d     = vca_pkg::RSN_FREE;
          cmd_d        = vca_pkg::CMD_NONE;
          unknown_d    = 1'b0;
          vstate_d     = vca_pkg::VS_STOPPED;
          state_d      = vca_pkg::ST_IDLE;
          case (op_q)
            vca_pkg::OP_PLAY: begin
              mem_we            = 1'b1;
              mem_wdata.handle  = play_cnt;
              mem_wdata.sound   = sound_q;
              mem_wdata.looping = loop_q;
              mem_wdata.paused  = 1'b0;
              valid_d[vic_idx]  = 1'b1;
              cnt_d             = play_cnt;
              new_handle_d      = play_cnt;
              chan_d            = sel_ext[2:0];
              reason_d          = vic_reason;
              cmd_d             = vca_pkg::CMD_START;
            end
            vca_pkg::OP_STOP: begin
              if (!match_found) begin
                unknown_d = 1'b1;
              end else begin
                valid_d[match_idx] = 1'b0;
                chan_d             = sel_ext[2:0];
                cmd_d              = vca_pkg::CMD_HALT;
              end
            end
            vca_pkg::OP_PAUSE: begin
              if (!match_found) begin
                unknown_d = 1'b1;
              end else begin
                chan_d = sel_ext[2:0];
                if (!match_entry.paused) begin
                  mem_we           = 1'b1;
                  mem_wdata.paused = 1'b1;
                  cmd_d            = vca_pkg::CMD_PAUSE;
                end
              end
            end
            vca_pkg::OP_RESUME: begin
              if (!match_found) begin
                unknown_d = 1'b1;
              end else begin
                chan_d = sel_ext[2:0];
                if (match_entry.paused) begin
                  mem_we           = 1'b1;
                  mem_wdata.paused = 1'b0;
                  cmd_d            = vca_pkg::CMD_RESUME;
                end
              end
            end
            vca_pkg::OP_QUERY: begin
              if (!match_found) begin
                unknown_d = 1'b1;
              end else begin
                chan_d   = sel_ext[2:0];
                vstate_d = match_entry.paused ? vca_pkg::VS_PAUSED : vca_pkg::VS_PLAYING;
              end
            end
            vca_pkg::OP_STOP_ALL: begin
              valid_d = '0;
              cmd_d   = vca_pkg::CMD_HALT_ALL;
            end
            vca_pkg::OP_TICK: begin
              for (int i = 0; i < TICK_N; i++) begin
                if (!mask_q[i]) valid_d[i] = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_d = vca_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vca_pkg::ST_IDLE;
      idx_q       <= '0;
      rd_pend_q   <= 1'b0;
      valid_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      rd_pend_q   <= (state_q == vca_pkg::ST_SCAN);
      valid_q     <= valid_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q     <= idx_q;
    new_handle_q <= new_handle_d;
    chan_q       <= chan_d;
    reason_q     <= reason_d;
    cmd_q        <= cmd_d;
    unknown_q    <= unknown_d;
    vstate_q     <= vstate_d;
    if (accept) begin
      op_q     <= op_in;
      sound_q  <= sound_id_i;
      loop_q   <= loop_request_i;
      target_q <= target_handle_i;
      mask_q   <= playing_mask_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == vca_pkg::ST_SCAN) begin
      rdata_q <= mem[idx_q];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign new_handle_o     = new_handle_q;
  assign channel_used_o   = chan_q;
  assign steal_reason_o   = reason_q;
  assign mixer_command_o  = cmd_q;
  assign handle_unknown_o = unknown_q;
  assign voice_state_o    = vstate_q;

`ifndef SYNTH
  a_start_has_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (mixer_command_o == vca_pkg::CMD_START) |-> new_handle_o != '0)
    else $error("start issued with zero handle");

  a_unknown_is_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && handle_unknown_o |->
      (mixer_command_o == vca_pkg::CMD_NONE) && (new_handle_o == '0))
    else $error("unknown handle produced a command");

  a_counter_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && (op_q == vca_pkg::OP_PLAY) |=> cnt_q != '0)
    else $error("handle counter zero after play");

  a_write_only_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> state_q == vca_pkg::ST_APPLY)
    else $error("channel memory written outside apply");

  a_no_read_in_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !rd_pend_q)
    else $error("read still pending while idle");
`endif

endmodule
